// ===== hdl/ray_box_slab_intersect_defines.svh =====
// ============================================================================
// Assertion macros for the ray/box slab test
// Shared property forms; each expects clk and arst_n in scope.
// ============================================================================
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define RBSI_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("rbsi: property violated");

// Check that a condition implies a consequence in the same cycle.
`define RBSI_ASSERT_IMPL(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("rbsi: implication violated");

`endif

// ===== hdl/rbsi_pkg.sv =====
// ============================================================================
// rbsi_pkg
// Types and constants shared by the ray/box slab test modules.
// ============================================================================
package rbsi_pkg;

	// Q16.16 signed fixed point
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
	localparam int NUM_AXES    = 3;
	// start accepted to done strobe, in cycles
	localparam int LATENCY     = 6;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;

	localparam prod_t PROD_COORD_MAX = prod_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam prod_t PROD_COORD_MIN = -PROD_COORD_MAX - prod_t'(1);
	localparam prod_t PROD_FRAC_BIAS = prod_t'({FRAC_BITS{1'b1}});

	typedef logic [2:0] cfg_idx_t;

	typedef enum logic [2:0] {
		REG_BOX_MIN_X = 3'd0,
		REG_BOX_MIN_Y = 3'd1,
		REG_BOX_MIN_Z = 3'd2,
		REG_BOX_MAX_X = 3'd3,
		REG_BOX_MAX_Y = 3'd4,
		REG_BOX_MAX_Z = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t inv_dir_x;
		coord_t inv_dir_y;
		coord_t inv_dir_z;
		coord_t t_start;
		coord_t t_end;
	} ray_t;

	typedef struct packed {
		logic   hit;
		coord_t t_enter;
		coord_t t_exit;
	} result_t;

	// ordered slab distances of one axis
	typedef struct packed {
		coord_t t_near;
		coord_t t_far;
	} slab_t;

	// ray distance interval carried alongside the lanes
	typedef struct packed {
		coord_t t_start;
		coord_t t_end;
	} span_t;

endpackage

// ===== hdl/rbsi_lane.sv =====
// ============================================================================
// rbsi_lane
// One axis of the slab test: differences, products, scaling, ordering.
// ============================================================================
module rbsi_lane (
	input  logic            clk,
	input  rbsi_pkg::coord_t corner_lo,
	input  rbsi_pkg::coord_t corner_hi,
	input  rbsi_pkg::coord_t origin,
	input  rbsi_pkg::coord_t inv_dir,
	output rbsi_pkg::slab_t  slab
);
	import rbsi_pkg::*;

	diff_t  diff_lo_s1, diff_hi_s1;
	coord_t inv_s1;
	prod_t  prod_lo_s2, prod_hi_s2;
	coord_t t_lo_s3, t_hi_s3;
	slab_t  slab_s4;

	// shift right by FRAC_BITS truncating toward zero, then clamp to coord range
	function automatic coord_t scale_sat(input prod_t p);
		prod_t adj;
		adj = p + (p[PROD_WIDTH-1] ? PROD_FRAC_BIAS : prod_t'(0));
		adj = adj >>> FRAC_BITS;
		if (adj > PROD_COORD_MAX)
			scale_sat = PROD_COORD_MAX[COORD_WIDTH-1:0];
		else if (adj < PROD_COORD_MIN)
			scale_sat = PROD_COORD_MIN[COORD_WIDTH-1:0];
		else
			scale_sat = adj[COORD_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk) begin
		diff_lo_s1 <= diff_t'(corner_lo) - diff_t'(origin);
		diff_hi_s1 <= diff_t'(corner_hi) - diff_t'(origin);
		inv_s1     <= inv_dir;

		prod_lo_s2 <= prod_t'(diff_lo_s1) * prod_t'(inv_s1);
		prod_hi_s2 <= prod_t'(diff_hi_s1) * prod_t'(inv_s1);

		t_lo_s3 <= scale_sat(prod_lo_s2);
		t_hi_s3 <= scale_sat(prod_hi_s2);

		// swap when out of order
		if (t_lo_s3 > t_hi_s3) begin
			slab_s4.t_near <= t_hi_s3;
			slab_s4.t_far  <= t_lo_s3;
		end else begin
			slab_s4.t_near <= t_lo_s3;
			slab_s4.t_far  <= t_hi_s3;
		end
	end

	assign slab = slab_s4;

endmodule

// ===== hdl/rbsi_merge.sv =====
// ============================================================================
// rbsi_merge
// Narrow the ray interval over all axes and form the result word.
// ============================================================================
module rbsi_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	input  rbsi_pkg::span_t   span,
	input  rbsi_pkg::slab_t   slabs [rbsi_pkg::NUM_AXES],
	output logic              done,
	output rbsi_pkg::result_t result
);
	import rbsi_pkg::*;

	coord_t  t0_c, t1_c;
	coord_t  t0_s5, t1_s5;
	logic    valid_s5;
	logic    done_q;
	result_t result_q;

	always_comb begin
		t0_c = span.t_start;
		t1_c = span.t_end;
		for (int a = 0; a < NUM_AXES; a++) begin
			if (slabs[a].t_near > t0_c)
				t0_c = slabs[a].t_near;
			if (slabs[a].t_far < t1_c)
				t1_c = slabs[a].t_far;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s5 <= valid;
			done_q   <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		t0_s5 <= t0_c;
		t1_s5 <= t1_c;
		// empty interval: zero the word
		if (t0_s5 > t1_s5) begin
			result_q <= '0;
		end else begin
			result_q.hit     <= 1'b1;
			result_q.t_enter <= t0_s5;
			result_q.t_exit  <= t1_s5;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hdl/ray_box_slab_intersect.sv =====
// ============================================================================
// ray_box_slab_intersect
// Ray versus axis-aligned box slab test in signed Q16.16 fixed point.
// ============================================================================
//
//  channel   handshake            word
//  -------   ------------------   ------------------------------------------
//  ray in    start / busy         ray     : origin, inverse direction, span
//  result    done (one cycle)     result  : hit, t_enter, t_exit
//  config    cfg_wr_en            cfg_index, cfg_wdata : box corner registers
//
//  One ray is taken every cycle; busy is always low.
//  Each result passes through these registers in order:
//  difference, 33x32 multiply, scale/saturate, order, merge, output register.
//  Results leave in the order the rays came in; the receiver cannot stall.
//  Reset clears the box registers to zero and empties the pipeline.
//
module ray_box_slab_intersect (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  rbsi_pkg::ray_t    ray,
	output logic              done,
	output rbsi_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  rbsi_pkg::cfg_idx_t cfg_index,
	input  rbsi_pkg::coord_t  cfg_wdata
);
	import rbsi_pkg::*;

	// box corners
	coord_t box_min_x_q, box_min_y_q, box_min_z_q;
	coord_t box_max_x_q, box_max_y_q, box_max_z_q;

	// valid flags and ray span alongside the lane stages
	logic  accept;
	logic  valid_s1, valid_s2, valid_s3, valid_s4;
	span_t span_s1, span_s2, span_s3, span_s4;

	slab_t slabs [NUM_AXES];

	// the pipeline never backs up, so a ray is always welcome
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration writes; drop writes to unused indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			box_max_z_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_min_x_q <= cfg_wdata;
				REG_BOX_MIN_Y: box_min_y_q <= cfg_wdata;
				REG_BOX_MIN_Z: box_min_z_q <= cfg_wdata;
				REG_BOX_MAX_X: box_max_x_q <= cfg_wdata;
				REG_BOX_MAX_Y: box_max_y_q <= cfg_wdata;
				REG_BOX_MAX_Z: box_max_z_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// advance the valid flags with the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// hold the ray span in step with the slab distances
	always_ff @(posedge clk) begin
		span_s1.t_start <= ray.t_start;
		span_s1.t_end   <= ray.t_end;
		span_s2         <= span_s1;
		span_s3         <= span_s2;
		span_s4         <= span_s3;
	end

	// one lane per axis, all working on the same ray
	rbsi_lane u_lane_x (
		.clk      (clk),
		.corner_lo(box_min_x_q),
		.corner_hi(box_max_x_q),
		.origin   (ray.origin_x),
		.inv_dir  (ray.inv_dir_x),
		.slab     (slabs[0])
	);

	rbsi_lane u_lane_y (
		.clk      (clk),
		.corner_lo(box_min_y_q),
		.corner_hi(box_max_y_q),
		.origin   (ray.origin_y),
		.inv_dir  (ray.inv_dir_y),
		.slab     (slabs[1])
	);

	rbsi_lane u_lane_z (
		.clk      (clk),
		.corner_lo(box_min_z_q),
		.corner_hi(box_max_z_q),
		.origin   (ray.origin_z),
		.inv_dir  (ray.inv_dir_z),
		.slab     (slabs[2])
	);

	// combine the three slabs with the ray span and register the result word
	rbsi_merge u_merge (
		.clk   (clk),
		.arst_n(arst_n),
		.valid (valid_s4),
		.span  (span_s4),
		.slabs (slabs),
		.done  (done),
		.result(result)
	);

endmodule

// ===== hdl/rbsi_checker.sv =====
// ============================================================================
// rbsi_checker
// Port-level checks on the slab test, bound to the top level.
// ============================================================================
`include "ray_box_slab_intersect_defines.svh"

module rbsi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input rbsi_pkg::result_t  result
);
	import rbsi_pkg::*;

	// every accepted ray yields exactly one word, a fixed time later
	`RBSI_ASSERT_ALWAYS(a_latency, done == $past(start && !busy && arst_n, LATENCY))

	// a miss carries zero distances
	`RBSI_ASSERT_IMPL(a_miss_zero, done && !result.hit, result.t_enter == 0 && result.t_exit == 0)

	// a hit never reports an empty interval
	`RBSI_ASSERT_IMPL(a_hit_order, done && result.hit, result.t_enter <= result.t_exit)

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);

// ===== sim/ray_box_slab_intersect_tb.sv =====
// ============================================================================
// ray_box_slab_intersect_tb
// Self-checking bench for the ray/box slab test. The box corners are loaded
// through the register port while the block is idle. Rays are then streamed
// in with random gaps. Every result is checked against a fixed-point model of
// the slab arithmetic. A short table of hand-picked rays comes first, then
// random rays under several box settings.
// ============================================================================
module ray_box_slab_intersect_tb;

	import rbsi_pkg::*;

	localparam int          RESET_CYCLES   = 6;
	localparam int          QUIET_LIMIT    = 200;
	localparam int          RAND_PHASES    = 8;
	localparam int          RAYS_PER_PHASE = 105;

	// register indexes the block does not decode; writes to them must be ignored
	localparam cfg_idx_t    REG_SPARE_6    = 3'd6;
	localparam cfg_idx_t    REG_SPARE_7    = 3'd7;

	localparam coord_t      Q_ZERO         = 32'sh0000_0000;
	localparam coord_t      Q_LSB          = 32'sh0000_0001;
	localparam coord_t      Q_HALF         = 32'sh0000_8000;
	localparam coord_t      Q_ONE          = 32'sh0001_0000;
	localparam coord_t      Q_TWO          = 32'sh0002_0000;
	localparam coord_t      Q_FOUR         = 32'sh0004_0000;
	localparam coord_t      Q_NEG_ONE      = 32'shFFFF_0000;
	localparam coord_t      Q_NEG_FOUR     = 32'shFFFC_0000;
	localparam coord_t      Q_NEG_LSB      = 32'shFFFF_FFFF;
	localparam coord_t      C_MAX          = 32'sh7FFF_FFFF;
	localparam coord_t      C_MIN          = 32'sh8000_0000;

	typedef enum int {
		BOX_AT_RESET,
		BOX_UNIT,
		BOX_WIDEST
	} box_pick_t;

	// one row of the directed table; want is only used where typed is set
	typedef struct {
		box_pick_t box;
		ray_t      ray;
		bit        typed;
		result_t   want;
	} ray_case_t;

	// ray word: origin x y z, inverse direction x y z, t_start, t_end
	ray_case_t directed_rays [$] = '{
		// box still at reset: every slab collapses to distance zero
		'{BOX_AT_RESET, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE, Q_ONE},
			1'b1, '{1'b1, Q_ZERO, Q_ZERO}},
		// reversed interval stays empty
		'{BOX_AT_RESET, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_NEG_ONE},
			1'b1, '{1'b0, Q_ZERO, Q_ZERO}},
		// touching interval t0 == t1 is a hit
		'{BOX_AT_RESET, '{Q_ZERO, Q_ZERO, Q_ZERO, C_MAX, C_MIN, Q_ZERO, Q_ZERO, Q_ZERO},
			1'b1, '{1'b1, Q_ZERO, Q_ZERO}},
		// unit box [-1, 1] seen from its centre
		'{BOX_UNIT, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_ONE, C_MIN, C_MAX},
			1'b1, '{1'b1, Q_NEG_ONE, Q_ONE}},
		// travel along x, zero direction on y and z (saturated inverse)
		'{BOX_UNIT, '{Q_NEG_FOUR, Q_ZERO, Q_ZERO, Q_ONE, C_MAX, C_MAX, Q_ZERO, C_MAX},
			1'b0, '0},
		// outside along a zero-direction axis: one distance saturates, the other lands one LSB above it
		'{BOX_UNIT, '{Q_ZERO, Q_TWO, Q_ZERO, Q_ONE, C_MAX, C_MAX, Q_ZERO, C_MAX},
			1'b0, '0},
		// negative direction: near and far swap
		'{BOX_UNIT, '{Q_FOUR, Q_ZERO, Q_ZERO, Q_NEG_ONE, C_MIN, C_MIN, Q_ZERO, C_MAX},
			1'b0, '0},
		// box behind the ray
		'{BOX_UNIT, '{Q_FOUR, Q_ZERO, Q_ZERO, Q_ONE, C_MAX, C_MAX, Q_ZERO, C_MAX},
			1'b0, '0},
		// origin on the upper face: zero difference with saturated inverse
		'{BOX_UNIT, '{Q_ONE, Q_ZERO, Q_ZERO, C_MAX, Q_ONE, Q_ONE, C_MIN, C_MAX},
			1'b0, '0},
		// all inverse directions zero
		'{BOX_UNIT, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, Q_ONE},
			1'b0, '0},
		// tiny product: negative distance truncates toward zero
		'{BOX_UNIT, '{Q_LSB, Q_ZERO, Q_ZERO, Q_LSB, Q_ONE, Q_ONE, C_MIN, C_MAX},
			1'b0, '0},
		// touching at the far face
		'{BOX_UNIT, '{Q_HALF, Q_HALF, Q_HALF, Q_ONE, Q_ONE, Q_ONE, Q_HALF, C_MAX},
			1'b0, '0},
		'{BOX_UNIT, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX},
			1'b0, '0},
		'{BOX_UNIT, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX},
			1'b0, '0},
		'{BOX_UNIT, '{C_MIN, C_MAX, Q_ZERO, C_MAX, C_MIN, Q_NEG_ONE, C_MAX, C_MAX},
			1'b0, '0},
		// full-range box: unit slope reproduces the corners
		'{BOX_WIDEST, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ONE, Q_ONE, Q_ONE, C_MIN, C_MAX},
			1'b1, '{1'b1, C_MIN, C_MAX}},
		'{BOX_WIDEST, '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX},
			1'b0, '0},
		'{BOX_WIDEST, '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX},
			1'b0, '0},
		'{BOX_WIDEST, '{Q_ZERO, Q_ZERO, Q_ZERO, Q_NEG_ONE, C_MIN, Q_LSB, C_MIN, C_MIN},
			1'b0, '0},
		'{BOX_WIDEST, '{Q_NEG_LSB, Q_NEG_LSB, Q_NEG_LSB, C_MAX, Q_NEG_LSB, C_MIN,
			C_MAX, C_MAX}, 1'b0, '0}
	};

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     start     = 1'b0;
	logic     busy;
	ray_t     ray       = '0;
	logic     done;
	result_t  result;
	logic     cfg_wr_en = 1'b0;
	cfg_idx_t cfg_index = '0;
	coord_t   cfg_wdata = '0;

	// local copy of the box registers, reset value zero
	coord_t   box_lo [NUM_AXES] = '{Q_ZERO, Q_ZERO, Q_ZERO};
	coord_t   box_hi [NUM_AXES] = '{Q_ZERO, Q_ZERO, Q_ZERO};

	// results owed by the block, oldest first
	result_t  owed_results [$];
	result_t  oldest_owed;

	int unsigned mismatches      = 0;
	int unsigned rays_sent       = 0;
	int unsigned results_checked = 0;
	int unsigned hits_seen       = 0;
	int unsigned quiet_cycles    = 0;

	ray_box_slab_intersect u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.ray       (ray),
		.done      (done),
		.result    (result),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Fixed-point slab model
	// ------------------------------------------------------------------

	// (corner - origin) * inv, exact, scaled down with truncation on the
	// magnitude, then clipped to the coordinate range
	function automatic coord_t slab_distance(coord_t corner, coord_t org, coord_t inv);
		diff_t gap;
		prod_t full;
		prod_t magnitude;
		prod_t scaled;
		gap       = diff_t'(corner) - diff_t'(org);
		full      = prod_t'(gap) * prod_t'(inv);
		magnitude = (full < 0) ? -full : full;
		scaled    = magnitude >> FRAC_BITS;
		if (full < 0) begin
			if (scaled > PROD_COORD_MAX)
				return C_MIN;
			return coord_t'(-scaled);
		end
		if (scaled > PROD_COORD_MAX)
			return C_MAX;
		return coord_t'(scaled);
	endfunction

	function automatic result_t predict_hit(ray_t r);
		coord_t  org [NUM_AXES];
		coord_t  inv [NUM_AXES];
		coord_t  t_near;
		coord_t  t_far;
		coord_t  swap_tmp;
		coord_t  t0;
		coord_t  t1;
		result_t res;
		org = '{r.origin_x, r.origin_y, r.origin_z};
		inv = '{r.inv_dir_x, r.inv_dir_y, r.inv_dir_z};
		t0  = r.t_start;
		t1  = r.t_end;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			t_near = slab_distance(box_lo[ax], org[ax], inv[ax]);
			t_far  = slab_distance(box_hi[ax], org[ax], inv[ax]);
			if (t_near > t_far) begin
				swap_tmp = t_near;
				t_near   = t_far;
				t_far    = swap_tmp;
			end
			if (t_near > t0)
				t0 = t_near;
			if (t_far < t1)
				t1 = t_far;
		end
		if (t0 > t1)
			res = '{1'b0, Q_ZERO, Q_ZERO};
		else
			res = '{1'b1, t0, t1};
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------

	// uniform in [lo, hi]; an inverted range collapses to lo
	function automatic coord_t pick_coord(coord_t lo, coord_t hi);
		longint span;
		span = longint'(hi) - longint'(lo);
		if (span < 0)
			return lo;
		return coord_t'(longint'(lo) + longint'($urandom_range(32'(span), 0)));
	endfunction

	// uniform in [-half, half]
	function automatic coord_t spread(int unsigned half);
		return coord_t'(longint'($urandom_range(2 * half, 0)) - longint'(half));
	endfunction

	// Most rays start in or near the current box with moderate slopes so that
	// the interval survives all three axes; the rest is raw noise.
	function automatic ray_t random_ray();
		coord_t org [NUM_AXES];
		coord_t inv [NUM_AXES];
		coord_t ts;
		coord_t te;
		longint shifted;
		for (int ax = 0; ax < NUM_AXES; ax++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: org[ax] = pick_coord(box_lo[ax], box_hi[ax]);
				4, 5, 6: begin
					shifted = longint'(pick_coord(box_lo[ax], box_hi[ax]))
						+ longint'(spread(1 << 22));
					if (shifted > longint'(C_MAX))
						shifted = C_MAX;
					else if (shifted < longint'(C_MIN))
						shifted = C_MIN;
					org[ax] = coord_t'(shifted);
				end
				7:       org[ax] = $urandom_range(1) ? C_MAX : C_MIN;
				default: org[ax] = coord_t'($urandom);
			endcase
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: inv[ax] = spread(1 << 20);
				6:       inv[ax] = $urandom_range(1) ? C_MAX : C_MIN;
				7:       inv[ax] = Q_ZERO;
				8:       inv[ax] = spread(1 << 8);
				default: inv[ax] = coord_t'($urandom);
			endcase
		end
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				ts = spread(1 << 16);
				te = pick_coord(Q_ZERO, C_MAX);
			end
			6: begin
				ts = pick_coord(Q_LSB, C_MAX);
				te = pick_coord(C_MIN, ts - Q_LSB);
			end
			7: begin
				ts = coord_t'($urandom);
				te = ts;
			end
			8: begin
				ts = coord_t'($urandom);
				te = coord_t'($urandom);
			end
			default: begin
				ts = C_MIN;
				te = C_MAX;
			end
		endcase
		return '{org[0], org[1], org[2], inv[0], inv[1], inv[2], ts, te};
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("ERROR rbsi @%0t result %0d: %s", $time, results_checked, what);
	endtask

	// Offer one ray word and hold it until taken. Leave start high so a
	// back-to-back word needs no second assignment in the same step.
	task automatic send_ray(input ray_t r, input bit typed, input result_t want);
		start <= 1'b1;
		ray   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		owed_results.push_back(typed ? want : predict_hit(r));
		rays_sent++;
	endtask

	// drop start for a burst; scramble the ray bus meanwhile
	task automatic idle_for(input int unsigned cycles);
		start <= 1'b0;
		ray   <= ray_t'({$urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom});
		repeat (cycles) @(posedge clk);
	endtask

	// drop start and hold off until every owed result has come back
	task automatic settle();
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input coord_t value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			REG_BOX_MIN_X: box_lo[0] = value;
			REG_BOX_MIN_Y: box_lo[1] = value;
			REG_BOX_MIN_Z: box_lo[2] = value;
			REG_BOX_MAX_X: box_hi[0] = value;
			REG_BOX_MAX_Y: box_hi[1] = value;
			REG_BOX_MAX_Z: box_hi[2] = value;
			default: ;
		endcase
	endtask

	// Reload all six corners once the pipeline is empty. The spare indexes go
	// last, so an aliased decode would corrupt a corner and show up.
	task automatic program_box(input coord_t min_x, input coord_t min_y, input coord_t min_z,
		input coord_t max_x, input coord_t max_y, input coord_t max_z);
		settle();
		write_reg(REG_BOX_MIN_X, min_x);
		write_reg(REG_BOX_MIN_Y, min_y);
		write_reg(REG_BOX_MIN_Z, min_z);
		write_reg(REG_BOX_MAX_X, max_x);
		write_reg(REG_BOX_MAX_Y, max_y);
		write_reg(REG_BOX_MAX_Z, max_z);
		write_reg(REG_SPARE_6, coord_t'($urandom));
		write_reg(REG_SPARE_7, coord_t'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Result check: done is a one-cycle strobe, so take it at every edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (owed_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result word hit=%0b t_enter=%h t_exit=%h",
					result.hit, result.t_enter, result.t_exit));
			end else begin
				oldest_owed = owed_results.pop_front();
				if (result.hit !== oldest_owed.hit)
					report_mismatch($sformatf("hit %0b, expected %0b",
						result.hit, oldest_owed.hit));
				if (result.t_enter !== oldest_owed.t_enter)
					report_mismatch($sformatf("t_enter %h, expected %h",
						result.t_enter, oldest_owed.t_enter));
				if (result.t_exit !== oldest_owed.t_exit)
					report_mismatch($sformatf("t_exit %h, expected %h",
						result.t_exit, oldest_owed.t_exit));
			end
			results_checked++;
			if (result.hit === 1'b1)
				hits_seen++;
		end
	end

	// Watchdog: give up after a long stretch with no word moving on any port
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d results outstanding",
				QUIET_LIMIT, owed_results.size());
			$display("ray_box_slab_intersect: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		box_pick_t   cur_box;
		int unsigned box_count;
		int unsigned idle_pct;
		int unsigned half;
		coord_t      centre;
		coord_t      lo_c [NUM_AXES];
		coord_t      hi_c [NUM_AXES];

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: box changes only between rows, with the pipeline empty
		cur_box   = BOX_AT_RESET;
		box_count = 1;
		foreach (directed_rays[i]) begin
			if (directed_rays[i].box != cur_box) begin
				cur_box = directed_rays[i].box;
				box_count++;
				if (cur_box == BOX_UNIT)
					program_box(Q_NEG_ONE, Q_NEG_ONE, Q_NEG_ONE, Q_ONE, Q_ONE, Q_ONE);
				else
					program_box(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
			end
			if ($urandom_range(2) == 0)
				idle_for($urandom_range(10, 1));
			send_ray(directed_rays[i].ray, directed_rays[i].typed, directed_rays[i].want);
		end

		// random phases, each under a fresh box
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			for (int ax = 0; ax < NUM_AXES; ax++) begin
				centre = spread(1 << 24);
				half   = $urandom_range(1 << 22, 1);
				case (phase)
					1: begin
						lo_c[ax] = C_MIN;
						hi_c[ax] = C_MAX;
					end
					3: begin
						// flat box: both faces coincide
						lo_c[ax] = centre;
						hi_c[ax] = centre;
					end
					5: begin
						// inverted box: lower corner above the upper one
						lo_c[ax] = centre + coord_t'(half);
						hi_c[ax] = centre - coord_t'(half);
					end
					default: begin
						lo_c[ax] = centre - coord_t'(half);
						hi_c[ax] = centre + coord_t'(half);
					end
				endcase
			end
			program_box(lo_c[0], lo_c[1], lo_c[2], hi_c[0], hi_c[1], hi_c[2]);
			box_count++;

			// the last phase streams flat out; the others pick a gap density
			case ($urandom_range(2))
				0:       idle_pct = 0;
				1:       idle_pct = 10;
				default: idle_pct = 35;
			endcase
			if (phase == RAND_PHASES - 1)
				idle_pct = 0;

			for (int n = 0; n < RAYS_PER_PHASE; n++) begin
				// hold the sender once mid-phase until the block has drained
				if (phase == 2 && n == RAYS_PER_PHASE / 2)
					settle();
				if ($urandom_range(99) < idle_pct)
					idle_for($urandom_range(10, 1));
				send_ray(random_ray(), 1'b0, '0);
			end
		end

		// drain, then keep clocking past the pipeline depth for stray strobes
		settle();
		repeat (LATENCY + 4) @(posedge clk);

		$display("rays sent %0d (%0d from the table), results checked %0d, hits %0d",
			rays_sent, directed_rays.size(), results_checked, hits_seen);
		$display("box settings %0d: reset, unit, full range, flat, inverted and random",
			box_count);
		if (mismatches == 0)
			$display("ray_box_slab_intersect: match");
		else
			$display("ray_box_slab_intersect: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/rbsi_pkg.sv
hdl/rbsi_lane.sv
hdl/rbsi_merge.sv
hdl/ray_box_slab_intersect.sv
hdl/rbsi_checker.sv
sim/ray_box_slab_intersect_tb.sv
